/* src/deq_pkg.sv */
`timescale 1ns / 1ps

package deq_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned OccW  = 5;

  // Operation codes of one request
  typedef enum logic [1:0] {
    OP_PUSH_REAR  = 2'd0,
    OP_PUSH_FRONT = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_REAR   = 2'd3
  } deq_op_e;

  // Completion status of one request
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_REAR_FULL = 2'd1,
    ST_NO_FRONT  = 2'd2,
    ST_EMPTY     = 2'd3
  } deq_status_e;

  // Storage action the back end carries out
  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2
  } deq_cmd_e;

  typedef struct packed {
    deq_op_e                  op;
    logic signed [DataW-1:0]  value;
  } deq_req_t;

  typedef struct packed {
    deq_status_e              status;
    logic signed [DataW-1:0]  popped;
    logic [OccW-1:0]          occupancy;
  } deq_res_t;

  // Classified request handed from front end to back end
  typedef struct packed {
    deq_cmd_e          kind;
    deq_status_e       status;
    logic [OccW-1:0]   occupancy;
    logic [DataW-1:0]  data;
  } deq_cmd_t;

endpackage

/* src/deq_fifo.sv */
`timescale 1ns / 1ps

module deq_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [Width-1:0]           data_i,
  output logic                       full_o,
  input  logic                       pop_i,
  output logic [Width-1:0]           data_o,
  output logic                       empty_o,
  output logic [$clog2(Depth+1)-1:0] count_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] slots_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign count_o = count_q;
  assign data_o  = slots_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Advance pointers with wrap at the last slot
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Hold entry payload
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* src/deq_front.sv */
`timescale 1ns / 1ps

module deq_front #(
  parameter int unsigned Depth = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  deq_pkg::deq_req_t         req_i,
  output deq_pkg::deq_cmd_t         cmd_o,
  output logic [$clog2(Depth)-1:0]  addr_o
);

  import deq_pkg::*;

  localparam int unsigned PosW  = $clog2(Depth + 1);
  localparam int unsigned AddrW = $clog2(Depth);

  logic [PosW-1:0] front_q, front_d;
  logic [PosW-1:0] rear_q, rear_d;
  logic [PosW-1:0] held;

  // Classify the request against the current indices
  always_comb begin
    front_d      = front_q;
    rear_d       = rear_q;
    cmd_o.kind   = CMD_NONE;
    cmd_o.status = ST_OK;
    cmd_o.data   = req_i.value;
    addr_o       = '0;
    unique case (req_i.op)
      OP_PUSH_REAR: begin
        if (rear_q == PosW'(Depth)) begin
          cmd_o.status = ST_REAR_FULL;
        end else begin
          cmd_o.kind = CMD_WRITE;
          addr_o     = AddrW'(rear_q);
          rear_d     = rear_q + PosW'(1);
          if (front_q == '0) begin
            front_d = PosW'(1);
          end
        end
      end
      OP_PUSH_FRONT: begin
        if (front_q <= PosW'(1)) begin
          cmd_o.status = ST_NO_FRONT;
        end else begin
          cmd_o.kind = CMD_WRITE;
          addr_o     = AddrW'(front_q - PosW'(2));
          front_d    = front_q - PosW'(1);
        end
      end
      OP_POP_FRONT: begin
        if (front_q == '0) begin
          cmd_o.status = ST_EMPTY;
        end else begin
          cmd_o.kind = CMD_READ;
          addr_o     = AddrW'(front_q - PosW'(1));
          if (front_q == rear_q) begin
            front_d = '0;
            rear_d  = '0;
          end else begin
            front_d = front_q + PosW'(1);
          end
        end
      end
      OP_POP_REAR: begin
        if (front_q == '0) begin
          cmd_o.status = ST_EMPTY;
        end else begin
          cmd_o.kind = CMD_READ;
          addr_o     = AddrW'(rear_q - PosW'(1));
          if (front_q == rear_q) begin
            front_d = '0;
            rear_d  = '0;
          end else begin
            rear_d = rear_q - PosW'(1);
          end
        end
      end
      default: begin
        cmd_o.kind = CMD_NONE;
      end
    endcase

    // Count what is held after the request
    held            = (front_d == '0) ? '0 : rear_d - front_d + PosW'(1);
    cmd_o.occupancy = OccW'(held);
  end

  // Advance indices on each accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      rear_q  <= '0;
    end else if (accept_i) begin
      front_q <= front_d;
      rear_q  <= rear_d;
    end
  end

endmodule

/* src/deq_back.sv */
`timescale 1ns / 1ps

module deq_back #(
  parameter int unsigned Depth    = 16,
  parameter int unsigned ResDepth = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cmd_valid_i,
  input  deq_pkg::deq_cmd_t            cmd_i,
  input  logic [$clog2(Depth)-1:0]     addr_i,
  output logic                         cmd_pop_o,
  input  logic [$clog2(ResDepth+1)-1:0] res_count_i,
  output logic                         res_push_o,
  output deq_pkg::deq_res_t            res_o
);

  import deq_pkg::*;

  localparam int unsigned CntW = $clog2(ResDepth + 1);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;
  logic             s1_valid_q;
  logic             s1_read_q;
  deq_status_e      s1_status_q;
  logic [OccW-1:0]  s1_occ_q;
  logic [CntW:0]    slots_used;
  logic             issue, do_write, do_read;

  // Issue only when the result queue has a slot for the request in flight
  assign slots_used = {1'b0, res_count_i} + {{CntW{1'b0}}, s1_valid_q};
  assign issue      = cmd_valid_i && (slots_used < (CntW + 1)'(ResDepth));
  assign cmd_pop_o  = issue;

  // Decode the storage action
  always_comb begin
    do_write = 1'b0;
    do_read  = 1'b0;
    unique case (cmd_i.kind)
      CMD_WRITE: do_write = issue;
      CMD_READ:  do_read  = issue;
      default: begin
        do_write = 1'b0;
        do_read  = 1'b0;
      end
    endcase
  end

  // Storage port: one write or one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (do_write) begin
      mem_q[addr_i] <= cmd_i.data;
    end
    if (do_read) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  // Hold request info alongside the read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_read_q   <= do_read;
      s1_status_q <= cmd_i.status;
      s1_occ_q    <= cmd_i.occupancy;
    end
  end

  // Form the result
  assign res_push_o      = s1_valid_q;
  assign res_o.status    = s1_status_q;
  assign res_o.popped    = s1_read_q ? rdata_q : '0;
  assign res_o.occupancy = s1_occ_q;

endmodule

/* src/double_ended_queue_top.sv */
`timescale 1ns / 1ps
// Channel   Direction  Handshake             Payload
// request   in         push / full           req_i  (op, value)
// result    out        pop / empty           res_o  (status, popped, occupancy)
//
// One result per request, via command queue, read register and result queue;
// one request per cycle if pop keeps up, set by the single-port storage array.
// Reset clears indices and queues; storage contents are not cleared.
// full rises when the two-entry command queue fills, which happens when the
// four-entry result queue backs up because pop stays low.

module double_ended_queue_top #(
  parameter int unsigned DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  deq_pkg::deq_req_t req_i,
  output logic              empty,
  input  logic              pop,
  output deq_pkg::deq_res_t res_o
);

  import deq_pkg::*;

  localparam int unsigned AddrW    = $clog2(DEPTH);
  localparam int unsigned CmdDepth = 2;
  localparam int unsigned ResDepth = 4;
  localparam int unsigned CmdW     = $bits(deq_cmd_t) + AddrW;
  localparam int unsigned ResW     = $bits(deq_res_t);

  deq_cmd_t                       fe_cmd, be_cmd;
  logic [AddrW-1:0]               fe_addr, be_addr;
  logic                           accept;
  logic                           cmd_empty, cmd_pop;
  logic [$clog2(CmdDepth+1)-1:0]  cmd_count;
  logic [CmdW-1:0]                cmd_head;
  logic                           res_push;
  deq_res_t                       be_res;
  logic [ResW-1:0]                res_head;
  logic [$clog2(ResDepth+1)-1:0]  res_count;

  assign accept = push && !full;

  deq_front #(
    .Depth (DEPTH)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .req_i    (req_i),
    .cmd_o    (fe_cmd),
    .addr_o   (fe_addr)
  );

  deq_fifo #(
    .Width (CmdW),
    .Depth (CmdDepth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({fe_addr, fe_cmd}),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_head),
    .empty_o (cmd_empty),
    .count_o (cmd_count)
  );

  assign be_addr = cmd_head[CmdW-1 -: AddrW];
  assign be_cmd  = cmd_head[$bits(deq_cmd_t)-1:0];

  deq_back #(
    .Depth    (DEPTH),
    .ResDepth (ResDepth)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!cmd_empty && (cmd_count != '0)),
    .cmd_i       (be_cmd),
    .addr_i      (be_addr),
    .cmd_pop_o   (cmd_pop),
    .res_count_i (res_count),
    .res_push_o  (res_push),
    .res_o       (be_res)
  );

  deq_fifo #(
    .Width (ResW),
    .Depth (ResDepth)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (be_res),
    .full_o  (),
    .pop_i   (pop),
    .data_o  (res_head),
    .empty_o (empty),
    .count_o (res_count)
  );

  assign res_o = res_head;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import deq_pkg::*;

  localparam int unsigned Depth      = 16;
  localparam int unsigned RandItems  = 1750;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned ShowLimit  = 10;

  logic     clk_i     = 1'b0;
  logic     rst_ni    = 1'b0;
  logic     req_push  = 1'b0;
  logic     res_pop   = 1'b0;
  deq_req_t req_data  = '0;
  logic     full;
  logic     empty;
  deq_res_t res_data;

  // Shadow deque, positions 1..Depth, front index zero means empty
  logic [DataW-1:0] shadow_slot [1:Depth];
  int unsigned      shadow_front = 0;
  int unsigned      shadow_rear  = 0;

  deq_res_t    pending_res [$];
  int unsigned fail_cnt  = 0;
  int unsigned cycle_cnt = 0;
  int unsigned rx_hold   = 0;

  double_ended_queue_top #(
    .DEPTH(Depth)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push  (req_push),
    .full  (full),
    .req_i (req_data),
    .empty (empty),
    .pop   (res_pop),
    .res_o (res_data)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // Apply one request to the shadow deque and return the result it gives
  function automatic deq_res_t deque_apply(deq_op_e op, logic [DataW-1:0] val);
    deq_res_t r;
    r.status = ST_OK;
    r.popped = '0;
    case (op)
      OP_PUSH_REAR: begin
        if (shadow_rear >= Depth) begin
          r.status = ST_REAR_FULL;
        end else begin
          shadow_rear++;
          shadow_slot[shadow_rear] = val;
          if (shadow_front == 0) shadow_front = 1;
        end
      end
      OP_PUSH_FRONT: begin
        if (shadow_front <= 1) begin
          r.status = ST_NO_FRONT;
        end else begin
          shadow_front--;
          shadow_slot[shadow_front] = val;
        end
      end
      OP_POP_FRONT: begin
        if (shadow_front == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.popped = shadow_slot[shadow_front];
          if (shadow_front == shadow_rear) begin
            shadow_front = 0;
            shadow_rear  = 0;
          end else begin
            shadow_front++;
          end
        end
      end
      default: begin
        if (shadow_front == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.popped = shadow_slot[shadow_rear];
          if (shadow_front == shadow_rear) begin
            shadow_front = 0;
            shadow_rear  = 0;
          end else begin
            shadow_rear--;
          end
        end
      end
    endcase
    r.occupancy = (shadow_front == 0) ? '0 : OccW'(shadow_rear - shadow_front + 1);
    return r;
  endfunction

  // Drive pop on a rotating stall pattern, or hold it low during a hold-off
  logic [7:0]  stall_pat = 8'hFF;
  int unsigned pat_age   = 0;
  always @(negedge clk_i) begin
    if (rx_hold > 0) begin
      res_pop <= 1'b0;
      rx_hold--;
    end else begin
      res_pop   <= stall_pat[0];
      stall_pat = {stall_pat[0], stall_pat[7:1]};
    end
    if (pat_age == 0) begin
      pat_age   = $urandom_range(16, 96);
      stall_pat = ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
    end else begin
      pat_age--;
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin : check_res
    deq_res_t want;
    if (rst_ni && res_pop && !empty) begin
      if (pending_res.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= ShowLimit)
          $display("unexpected result: status %0d popped %h occupancy %0d",
                   res_data.status, res_data.popped, res_data.occupancy);
      end else begin
        want = pending_res.pop_front();
        if (res_data.status !== want.status || res_data.popped !== want.popped ||
            res_data.occupancy !== want.occupancy) begin
          fail_cnt++;
          if (fail_cnt <= ShowLimit)
            $display("mismatch: status %0d/%0d popped %h/%h occupancy %0d/%0d (exp/got)",
                     want.status, res_data.status, want.popped, res_data.popped,
                     want.occupancy, res_data.occupancy);
        end
      end
    end
  end

  // Offer one request and record its expected result once taken
  task automatic send_req(deq_op_e op, logic [DataW-1:0] val);
    @(negedge clk_i);
    req_push <= 1'b1;
    req_data <= '{op: op, value: val};
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    pending_res.push_back(deque_apply(op, val));
  endtask

  // Hold push low for a number of cycles
  task automatic idle_req(int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      req_push <= 1'b0;
    end
  endtask

  // Stop sending and wait for every outstanding result
  task automatic wait_drain();
    idle_req(1);
    while (pending_res.size() != 0) @(posedge clk_i);
  endtask

  function automatic deq_op_e pick_op(int unsigned bias);
    int unsigned r;
    r = $urandom_range(0, 99);
    case (bias)
      1: return (r < 55) ? OP_PUSH_REAR : (r < 75) ? OP_PUSH_FRONT :
                (r < 90) ? OP_POP_FRONT : OP_POP_REAR;
      2: return (r < 10) ? OP_PUSH_REAR : (r < 20) ? OP_PUSH_FRONT :
                (r < 60) ? OP_POP_FRONT : OP_POP_REAR;
      3: return (r < 10) ? OP_PUSH_REAR : (r < 50) ? OP_PUSH_FRONT :
                (r < 90) ? OP_POP_FRONT : OP_POP_REAR;
      default: return (r < 30) ? OP_PUSH_REAR : (r < 50) ? OP_PUSH_FRONT :
                      (r < 75) ? OP_POP_FRONT : OP_POP_REAR;
    endcase
  endfunction

  function automatic logic [DataW-1:0] pick_value();
    case ($urandom_range(0, 11))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Underflow at both ends, front push on empty, pop of the last element
  task automatic test_empty_edges();
    send_req(OP_POP_FRONT, 32'h1234_5678);
    send_req(OP_POP_REAR, 32'hFFFF_FFFF);
    send_req(OP_PUSH_FRONT, 32'h5555_5555);
    send_req(OP_PUSH_REAR, 32'hAAAA_AAAA);
    send_req(OP_POP_FRONT, 32'h0);
    wait_drain();
  endtask

  // Fill to the rear limit, refuse both pushes, then reopen front room
  task automatic test_fill_rear();
    for (int unsigned i = 0; i < Depth; i++)
      send_req(OP_PUSH_REAR, i[0] ? 32'h8000_0000 + i : 32'h7FFF_FFFF - i);
    send_req(OP_PUSH_REAR, 32'hDEAD_BEEF);
    send_req(OP_PUSH_FRONT, 32'hCAFE_F00D);
    send_req(OP_POP_FRONT, 32'h0);
    send_req(OP_PUSH_FRONT, 32'hFFFF_FFFF);
    wait_drain();
  endtask

  // Stall the receiver long enough to fill the block while requests keep coming
  task automatic test_backpressure();
    rx_hold = 200;
    for (int unsigned i = 0; i < 40; i++) send_req(pick_op(0), pick_value());
    wait_drain();
  endtask

  // Random bursts under shifting op mixes, with one full pause midway
  task automatic test_random_mix();
    int unsigned sent;
    int unsigned burst;
    int unsigned bias;
    sent = 0;
    bias = 0;
    while (sent < RandItems) begin
      if ($urandom_range(0, 15) == 0) bias = $urandom_range(0, 3);
      burst = $urandom_range(1, 16);
      for (int unsigned i = 0; i < burst && sent < RandItems; i++) begin
        send_req(pick_op(bias), pick_value());
        sent++;
        if (sent == RandItems / 2) wait_drain();
      end
      if ($urandom_range(0, 3) != 0) idle_req($urandom_range(1, 8));
    end
    wait_drain();
  endtask

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_empty_edges();
    test_fill_rear();
    test_backpressure();
    test_random_mix();
    repeat (8) @(posedge clk_i);
    if (fail_cnt == 0 && pending_res.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
